@@ rtl/core/iuhb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package iuhb_pkg;

	// Item kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Header layout and fixed field values
	localparam int unsigned HDR_BYTES     = 28;
	localparam int unsigned UDP_HDR_BYTES = 8;
	localparam int unsigned IDX_W         = 5;
	localparam int unsigned SUM_W         = 19;
	localparam logic [7:0]  VER_IHL       = 8'h45;
	localparam logic [7:0]  IP_TTL        = 8'h80;
	localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
	localparam logic [15:0] FALLBACK_PORT = 16'd6881;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_BYTES - 1);

	// Input transfer payload
	typedef struct packed {
		logic        kind;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_length;
		logic [15:0] room_bytes;
		logic [7:0]  payload_byte;
		logic        payload_end;
	} in_item_t;

	// Output transfer payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       too_small;
	} out_item_t;

	// Classified command passed from front to back
	typedef struct packed {
		logic             kind;
		logic             too_small;
		logic [31:0]      src_addr;
		logic [31:0]      dst_addr;
		logic [15:0]      src_port;
		logic [15:0]      dst_port;
		logic [15:0]      total_len;
		logic [15:0]      udp_len;
		logic [SUM_W-1:0] raw_sum;
		logic [7:0]       payload_byte;
		logic             payload_end;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/iuhb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module iuhb_front
	import iuhb_pkg::*;
(
	input  wire in_item_t item,
	output cmd_t          cmd
);

	logic [16:0] frame_len;
	logic [15:0] total_len;

	// Room check on the full 17-bit length
	assign frame_len = {1'b0, item.payload_length} + 17'(HDR_BYTES);
	assign total_len = frame_len[15:0];

	always_comb begin
		cmd.kind         = item.kind;
		cmd.too_small    = (frame_len > {1'b0, item.room_bytes});
		cmd.src_addr     = item.src_addr;
		cmd.dst_addr     = item.dst_addr;
		cmd.src_port     = (item.src_port == 16'd0) ? FALLBACK_PORT : item.src_port;
		cmd.dst_port     = item.dst_port;
		cmd.total_len    = total_len;
		cmd.udp_len      = item.payload_length + 16'(UDP_HDR_BYTES);
		cmd.payload_byte = item.payload_byte;
		cmd.payload_end  = item.payload_end;
		// Unfolded sum of the IPv4 header words, checksum word taken as zero
		cmd.raw_sum      = SUM_W'({VER_IHL, 8'h00}) + SUM_W'({IP_TTL, IP_PROTO_UDP})
			+ SUM_W'(total_len)
			+ SUM_W'(item.src_addr[31:16]) + SUM_W'(item.src_addr[15:0])
			+ SUM_W'(item.dst_addr[31:16]) + SUM_W'(item.dst_addr[15:0]);
	end

endmodule

`default_nettype wire

@@ rtl/core/iuhb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module iuhb_fifo
	import iuhb_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire cmd_t  push_data,
	output logic       full,
	input  wire        pop,
	output cmd_t       head,
	output logic       empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/iuhb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module iuhb_back
	import iuhb_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire cmd_t   head,
	input  wire         empty,
	output logic        pop,
	output logic        result_valid,
	input  wire         result_ready,
	output out_item_t   result
);

	// One's-complement fold and invert of the raw header sum
	function automatic logic [15:0] ip_checksum(input logic [SUM_W-1:0] raw);
		logic [16:0] s1;
		logic [16:0] s2;
		s1 = {1'b0, raw[15:0]} + 17'(raw[SUM_W-1:16]);
		s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
		return ~s2[15:0];
	endfunction

	// Header byte at a given position, network byte order
	function automatic logic [7:0] hdr_byte(input cmd_t c, input logic [15:0] chk,
		input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = VER_IHL;
			5'd2:    b = c.total_len[15:8];
			5'd3:    b = c.total_len[7:0];
			5'd8:    b = IP_TTL;
			5'd9:    b = IP_PROTO_UDP;
			5'd10:   b = chk[15:8];
			5'd11:   b = chk[7:0];
			5'd12:   b = c.src_addr[31:24];
			5'd13:   b = c.src_addr[23:16];
			5'd14:   b = c.src_addr[15:8];
			5'd15:   b = c.src_addr[7:0];
			5'd16:   b = c.dst_addr[31:24];
			5'd17:   b = c.dst_addr[23:16];
			5'd18:   b = c.dst_addr[15:8];
			5'd19:   b = c.dst_addr[7:0];
			5'd20:   b = c.src_port[15:8];
			5'd21:   b = c.src_port[7:0];
			5'd22:   b = c.dst_port[15:8];
			5'd23:   b = c.dst_port[7:0];
			5'd24:   b = c.udp_len[15:8];
			5'd25:   b = c.udp_len[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	cmd_t             cur_q;
	logic [15:0]      chk_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             load;
	logic             start_hdr;
	logic             out_set;
	out_item_t        out_d;
	logic [15:0]      head_chk;

	assign load         = !out_valid_q || result_ready;
	assign head_chk     = ip_checksum(head.raw_sum);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Pick the next output byte: header in progress first, then the queue head
	always_comb begin
		pop       = 1'b0;
		start_hdr = 1'b0;
		out_set   = 1'b0;
		out_d     = '0;
		if (load) begin
			if (busy_q) begin
				out_set        = 1'b1;
				out_d.out_byte = hdr_byte(cur_q, chk_q, idx_q);
				out_d.last     = (idx_q == LAST_IDX);
			end else if (!empty) begin
				pop     = 1'b1;
				out_set = 1'b1;
				if (head.kind == KIND_PAYLOAD) begin
					out_d.out_byte = head.payload_byte;
					out_d.last     = head.payload_end;
				end else if (head.too_small) begin
					out_d.last      = 1'b1;
					out_d.too_small = 1'b1;
				end else begin
					start_hdr      = 1'b1;
					out_d.out_byte = VER_IHL;
				end
			end
		end
	end

	// Header context
	always_ff @(posedge clk) begin
		if (start_hdr) begin
			cur_q <= head;
			chk_q <= head_chk;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_hdr) begin
				busy_q <= 1'b1;
				idx_q  <= IDX_W'(1);
			end else if (load && busy_q) begin
				busy_q <= (idx_q != LAST_IDX);
				idx_q  <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= out_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_set) begin
			out_q <= out_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ipv4_udp_header_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// IPv4 + UDP header builder. Each input transfer is either a header request or one
// payload byte. A request that fits its room yields the 28 header bytes (IPv4 with
// TTL 128, protocol UDP, computed header checksum; UDP with zero checksum and port
// 6881 if the source port is zero), last set on the final byte; a request whose
// payload plus 28 exceeds room_bytes yields a single transfer with too_small and
// last set. A payload byte yields one transfer with last copied from payload_end.
// The front classifies and precomputes lengths and the header sum in the accept
// cycle and writes a command queue of QUEUE_DEPTH entries; the back sequencer emits
// one byte per cycle, unless result_ready holds it, through a registered output.
// Payload bytes flow at one per cycle on the same terms; a header occupies the
// output for its 28 bytes while the queue keeps accepting until full.
module ipv4_udp_header_builder
	import iuhb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          item_valid,
	output logic         item_ready,
	input  wire in_item_t item,
	output logic         result_valid,
	input  wire          result_ready,
	output out_item_t    result
);

	cmd_t cmd;
	cmd_t head;
	logic full;
	logic empty;
	logic pop;

	assign item_ready = !full;

	// Classify the incoming transfer
	iuhb_front u_front (
		.item (item),
		.cmd  (cmd)
	);

	// Command queue between front and back
	iuhb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid),
		.push_data (cmd),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// Byte sequencer
	iuhb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import iuhb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_PRINTED = 40;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	// Idle rates in percent, long stall request, run bookkeeping
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	int unsigned stall_request  = 0;
	int unsigned stall_left     = 0;
	int unsigned cycle_count    = 0;
	int unsigned mismatch_count = 0;
	int unsigned bytes_seen     = 0;
	out_item_t   frame_bytes_due[$];

	ipv4_udp_header_builder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	// Expected frame bytes for one accepted item
	function automatic void build_frame_bytes(input in_item_t it);
		out_item_t              ob;
		int unsigned            plen;
		logic [15:0]            total_len;
		logic [15:0]            udp_len;
		logic [15:0]            sport;
		logic [15:0]            hdr_chk;
		logic [31:0]            acc;
		logic [HDR_BYTES*8-1:0] hdr;
		if (it.kind == KIND_PAYLOAD) begin
			ob.out_byte  = it.payload_byte;
			ob.last      = it.payload_end;
			ob.too_small = 1'b0;
			frame_bytes_due.push_back(ob);
			return;
		end
		plen = it.payload_length;
		// request does not fit: one error transfer, no header
		if (plen + HDR_BYTES > int'(it.room_bytes)) begin
			ob.out_byte  = 8'h00;
			ob.last      = 1'b1;
			ob.too_small = 1'b1;
			frame_bytes_due.push_back(ob);
			return;
		end
		total_len = 16'(plen + HDR_BYTES);
		udp_len   = 16'(plen + UDP_HDR_BYTES);
		sport     = (it.src_port == 16'h0000) ? FALLBACK_PORT : it.src_port;
		// ones' complement sum; id, flags and checksum words are zero
		acc = {16'h0000, VER_IHL, 8'h00} + total_len + {IP_TTL, IP_PROTO_UDP}
			+ it.src_addr[31:16] + it.src_addr[15:0]
			+ it.dst_addr[31:16] + it.dst_addr[15:0];
		acc = acc[15:0] + acc[31:16];
		acc = acc[15:0] + acc[31:16];
		hdr_chk = ~acc[15:0];
		hdr = {VER_IHL, 8'h00, total_len, 16'h0000, 16'h0000, IP_TTL, IP_PROTO_UDP,
			hdr_chk, it.src_addr, it.dst_addr, sport, it.dst_port, udp_len, 16'h0000};
		for (int unsigned i = 0; i < HDR_BYTES; i++) begin
			ob.out_byte  = hdr[HDR_BYTES*8-1-8*i -: 8];
			ob.last      = (i == HDR_BYTES - 1);
			ob.too_small = 1'b0;
			frame_bytes_due.push_back(ob);
		end
	endfunction

	// Item generators; fields the block ignores stay random
	function automatic in_item_t random_fields();
		in_item_t it;
		it.kind           = 1'($urandom);
		it.src_addr       = $urandom;
		it.dst_addr       = $urandom;
		it.src_port       = 16'($urandom);
		it.dst_port       = 16'($urandom);
		it.payload_length = 16'($urandom);
		it.room_bytes     = 16'($urandom);
		it.payload_byte   = 8'($urandom);
		it.payload_end    = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t header_req(input logic [31:0] sa, input logic [31:0] da,
			input logic [15:0] sp, input logic [15:0] dp, input logic [15:0] plen,
			input logic [15:0] room);
		in_item_t it;
		it                = random_fields();
		it.kind           = KIND_HEADER;
		it.src_addr       = sa;
		it.dst_addr       = da;
		it.src_port       = sp;
		it.dst_port       = dp;
		it.payload_length = plen;
		it.room_bytes     = room;
		return it;
	endfunction

	function automatic in_item_t payload_item(input logic [7:0] b, input logic e);
		in_item_t it;
		it              = random_fields();
		it.kind         = KIND_PAYLOAD;
		it.payload_byte = b;
		it.payload_end  = e;
		return it;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED) begin
			$display("%s", msg);
		end
	endtask

	// Offer one item, with random idle cycles ahead of it; returns at the accepting edge
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		build_frame_bytes(it);
		do @(posedge clk); while (item_ready !== 1'b1);
	endtask

	// Receiver: random idling, or a long hold-off on request
	always @(posedge clk) begin
		if (stall_request != 0) begin
			stall_left    = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transfer with the oldest expected byte
	always @(posedge clk) begin : check_result
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (frame_bytes_due.size() == 0) begin
				flag_mismatch($sformatf("ERROR transfer %0d: unexpected, byte %02h",
					bytes_seen, result.out_byte));
			end else begin
				want = frame_bytes_due.pop_front();
				if (result.out_byte !== want.out_byte)
					flag_mismatch($sformatf("ERROR transfer %0d: out_byte %02h, expected %02h",
						bytes_seen, result.out_byte, want.out_byte));
				if (result.last !== want.last)
					flag_mismatch($sformatf("ERROR transfer %0d: last %b, expected %b",
						bytes_seen, result.last, want.last));
				if (result.too_small !== want.too_small)
					flag_mismatch($sformatf("ERROR transfer %0d: too_small %b, expected %b",
						bytes_seen, result.too_small, want.too_small));
			end
			bytes_seen++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ipv4_udp_header_builder: mismatch");
			$finish;
		end
	end

	// Field extremes, room boundaries, fallback port, checksum corners, payload bytes
	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// all zero, fits exactly, fallback port
		send_item(header_req(32'h0, 32'h0, 16'h0, 16'h0, 16'd0, 16'd28));
		// all ones: carries folded back into the sum
		send_item(header_req('1, '1, 16'hffff, 16'hffff, 16'd0, 16'hffff));
		// largest payload that fits, then one byte short of room
		send_item(header_req('1, '1, 16'h0001, 16'hffff, 16'd65507, 16'd65535));
		send_item(header_req('1, '1, 16'h0001, 16'hffff, 16'd65507, 16'd65534));
		// empty payload with one byte too little room, and zero room
		send_item(header_req(32'h01020304, 32'h05060708, 16'd80, 16'd80, 16'd0, 16'd27));
		send_item(header_req(32'h01020304, 32'h05060708, 16'd80, 16'd80, 16'd0, 16'd0));
		// length beyond the UDP limit
		send_item(header_req('1, '1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
		// sum comes out at ffff, so the checksum is zero
		send_item(header_req(32'h3ad20000, 32'h0, 16'd1234, 16'd53, 16'd0, 16'd100));
		send_item(header_req(32'hc0a80001, 32'hc0a800c7, 16'h0, 16'd53, 16'd18, 16'd46));
		send_item(header_req(32'h0a000001, 32'h0a000002, 16'h8000, 16'h0001, 16'd100,
			16'hffff));
		send_item(payload_item(8'h00, 1'b0));
		send_item(payload_item(8'ha5, 1'b0));
		send_item(payload_item(8'hff, 1'b1));
	endtask

	// Mostly well-formed datagrams, plus lone requests and stray payload bytes
	task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
			input int unsigned n_items);
		in_item_t    it;
		int unsigned sent;
		int unsigned plen;
		int unsigned pick;
		logic [15:0] sport;
		sent          = 0;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				plen  = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 0);
				sport = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
				send_item(header_req($urandom, $urandom, sport, 16'($urandom), 16'(plen),
					16'($urandom_range(65535, plen + HDR_BYTES))));
				sent++;
				for (int unsigned k = 0; k < plen; k++) begin
					send_item(payload_item(8'($urandom), k == plen - 1));
					sent++;
				end
			end else if (pick < 90) begin
				// unconstrained lengths: about half do not fit
				it      = random_fields();
				it.kind = KIND_HEADER;
				send_item(it);
				sent++;
			end else begin
				send_item(payload_item(8'($urandom), 1'($urandom)));
				sent++;
			end
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_input_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 300;
		for (int unsigned d = 0; d < 3; d++) begin
			send_item(header_req($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd4,
				16'hffff));
			for (int unsigned k = 0; k < 4; k++) begin
				send_item(payload_item(8'($urandom), k == 3));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(37, 71, 67);
		test_random_traffic(71, 37, 67);
		test_input_backpressure();
		test_random_traffic(0, 0, 68);
		item_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ipv4_udp_header_builder: match");
		end else begin
			$display("ipv4_udp_header_builder: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/iuhb_pkg.sv
rtl/core/iuhb_front.sv
rtl/core/iuhb_fifo.sv
rtl/core/iuhb_back.sv
rtl/core/ipv4_udp_header_builder.sv
bench/tb_top.sv
